>>> sv/cpcr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the circle pair collision resolver.
package cpcr_pkg;

   localparam int REST_W     = 9;
   localparam int REST_ONE   = 256;
   localparam int REST_SHIFT = 8;
   localparam int DIST_EXTRA = 14;
   localparam int VEL_QW     = 25;
   localparam int POS_QW     = 17;
   localparam int LATENCY    = 58;

   typedef struct packed {
      logic signed [23:0] vax;
      logic signed [23:0] vay;
      logic signed [23:0] vbx;
      logic signed [23:0] vby;
      logic signed [23:0] pax;
      logic signed [23:0] pay;
      logic signed [23:0] pbx;
      logic signed [23:0] pby;
   } kin_type;

   typedef struct packed {
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic signed [24:0] dvx;
      logic signed [24:0] dvy;
      logic [16:0]        s;
      logic [24:0]        msum;
      logic [9:0]         f;
      logic [23:0]        ma;
      logic [23:0]        mb;
   } st1_type;

   typedef struct packed {
      logic [48:0]        dx2;
      logic [48:0]        dy2;
      logic [33:0]        ss;
      logic signed [49:0] px;
      logic signed [49:0] py;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic [16:0]        s;
      logic [24:0]        msum;
      logic [9:0]         f;
      logic [23:0]        ma;
      logic [23:0]        mb;
   } st2_type;

   typedef struct packed {
      logic [49:0]        d2;
      logic signed [50:0] num;
      logic [33:0]        ss;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic [16:0]        s;
      logic [24:0]        msum;
      logic [9:0]         f;
      logic [23:0]        ma;
      logic [23:0]        mb;
   } st3_type;

   typedef struct packed {
      logic hit;
      logic nz;
      logic appr;
      logic negx;
      logic negy;
   } flag_type;

   typedef struct packed {
      flag_type    flg;
      logic [16:0] adx;
      logic [16:0] ady;
      logic [33:0] d2t;
      logic [41:0] numabs;
      logic [16:0] s;
      logic [24:0] msum;
      logic [9:0]  f;
      logic [23:0] ma;
      logic [23:0] mb;
   } st4_type;

   typedef struct packed {
      logic [40:0] mb_adx;
      logic [40:0] mb_ady;
      logic [40:0] ma_adx;
      logic [40:0] ma_ady;
   } mterm_type;

   typedef struct packed {
      logic [VEL_QW:0] ax;
      logic [VEL_QW:0] ay;
      logic [VEL_QW:0] bx;
      logic [VEL_QW:0] by;
   } vq_type;

   // Adds or subtracts a magnitude and clamps to the 24-bit signed range.
   function automatic logic signed [23:0] adj_sat(input logic signed [23:0] v,
                                                  input logic [25:0] mag,
                                                  input logic sub);
      logic signed [26:0] m;
      logic signed [26:0] w;
      m = $signed({1'b0, mag});
      w = sub ? (27'(v) - m) : (27'(v) + m);
      if (w > 27'sd8388607) begin
         return 24'sh7fffff;
      end else if (w < -27'sd8388608) begin
         return 24'sh800000;
      end else begin
         return w[23:0];
      end
   endfunction

endpackage

>>> sv/circle_pair_collision_resolve_core.sv
`timescale 1ns / 1ps
// Top level of the circle pair collision resolver: impulse and overlap correction per pair.
//
// Usage: a pair of circles is presented on the req_ ports with start high; since busy
// is always low, a transfer happens at every clock edge where start is high, so one
// pair can enter in every cycle. Each pair yields exactly one result on the rsp_ ports,
// marked by rsp_valid for one cycle, in input order. The pipeline is fixed-length: four
// front stages, the square root of the squared distance (31 stages), one overlap stage,
// the position product (3 stages), the position quotient (18 stages) and the output
// register make up the position path; the velocity path is shorter and is delayed to
// match. Throughput is one pair per cycle. The receiver cannot stall the block, so
// nothing is held back or repeated. The restitution register is written through the
// csr_ channel (always ready); the user must write it only while no pair is in flight,
// as the block itself does not enforce this. Synchronous reset clears the valid chain
// and sets restitution to fully elastic (256); pairs in flight at reset are dropped.
module circle_pair_collision_resolve_core
   import cpcr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [23:0]  req_pos_a_x,
   input  logic signed [23:0]  req_pos_a_y,
   input  logic signed [23:0]  req_vel_a_x,
   input  logic signed [23:0]  req_vel_a_y,
   input  logic [15:0]         req_radius_a,
   input  logic [23:0]         req_mass_a,
   input  logic signed [23:0]  req_pos_b_x,
   input  logic signed [23:0]  req_pos_b_y,
   input  logic signed [23:0]  req_vel_b_x,
   input  logic signed [23:0]  req_vel_b_y,
   input  logic [15:0]         req_radius_b,
   input  logic [23:0]         req_mass_b,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [REST_W-1:0]   csr_wdata,
   output logic                rsp_valid,
   output logic                rsp_collided,
   output logic signed [23:0]  rsp_new_vel_a_x,
   output logic signed [23:0]  rsp_new_vel_a_y,
   output logic signed [23:0]  rsp_new_vel_b_x,
   output logic signed [23:0]  rsp_new_vel_b_y,
   output logic signed [23:0]  rsp_new_pos_a_x,
   output logic signed [23:0]  rsp_new_pos_a_y,
   output logic signed [23:0]  rsp_new_pos_b_x,
   output logic signed [23:0]  rsp_new_pos_b_y
);

   logic [LATENCY-1:0] valid_in, valid_ff;
   logic [REST_W-1:0]  restitution_in, restitution_ff;
   logic [REST_W-1:0]  rest_clip;

   st1_type st1_in, st1_ff;
   st2_type st2_in, st2_ff;
   st3_type st3_in, st3_ff;
   st4_type st4_in, st4_ff;

   logic [51:0] a_in, a_ff;
   mterm_type   mt_in, mt_ff;
   logic [58:0] dv_in, dv_ff;
   logic [27:0] m5_in, m5_ff;
   logic [16:0] s5_in, s5_ff;

   kin_type    kin_req, kin_d, res_in, res_ff;
   flag_type   flg_d;
   logic       collided_in, collided_ff;

   logic [58:0]     dv_d;
   logic [92:0]     nv_ax, nv_ay, nv_bx, nv_by;
   vq_type          vq, vq_d;
   logic [30:0]     root;
   logic [16:0]     s_a;
   logic [27:0]     m5_a;
   mterm_type       mt_b;
   logic [30:0]     ov;
   logic [32:0]     ov4_in, ov4_ff;
   logic [58:0]     dpos_in, dpos_ff, dpos_d;
   logic [73:0]     np_ax, np_ay, np_bx, np_by;
   logic [POS_QW:0] pq_ax, pq_ay, pq_bx, pq_by;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign valid_in       = {valid_ff[LATENCY-2:0], start && !busy};
   assign restitution_in = (csr_valid && csr_ready) ? csr_wdata : restitution_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         restitution_ff <= REST_W'(REST_ONE);
      end else begin
         valid_ff       <= valid_in;
         restitution_ff <= restitution_in;
      end
   end

   always_comb begin
      rest_clip = (restitution_ff > REST_W'(REST_ONE)) ? REST_W'(REST_ONE) : restitution_ff;
      st1_in.dx   = 25'(req_pos_b_x) - 25'(req_pos_a_x);
      st1_in.dy   = 25'(req_pos_b_y) - 25'(req_pos_a_y);
      st1_in.dvx  = 25'(req_vel_b_x) - 25'(req_vel_a_x);
      st1_in.dvy  = 25'(req_vel_b_y) - 25'(req_vel_a_y);
      st1_in.s    = 17'(req_radius_a) + 17'(req_radius_b);
      st1_in.msum = 25'(req_mass_a) + 25'(req_mass_b);
      st1_in.f    = 10'(REST_ONE) + 10'(rest_clip);
      st1_in.ma   = req_mass_a;
      st1_in.mb   = req_mass_b;
   end

   always_comb begin
      st2_in.dx2  = 49'(50'(st1_ff.dx) * 50'(st1_ff.dx));
      st2_in.dy2  = 49'(50'(st1_ff.dy) * 50'(st1_ff.dy));
      st2_in.ss   = 34'(st1_ff.s) * 34'(st1_ff.s);
      st2_in.px   = 50'(st1_ff.dvx) * 50'(st1_ff.dx);
      st2_in.py   = 50'(st1_ff.dvy) * 50'(st1_ff.dy);
      st2_in.dx   = st1_ff.dx;
      st2_in.dy   = st1_ff.dy;
      st2_in.s    = st1_ff.s;
      st2_in.msum = st1_ff.msum;
      st2_in.f    = st1_ff.f;
      st2_in.ma   = st1_ff.ma;
      st2_in.mb   = st1_ff.mb;
   end

   always_comb begin
      st3_in.d2   = 50'(st2_ff.dx2) + 50'(st2_ff.dy2);
      st3_in.num  = 51'(st2_ff.px) + 51'(st2_ff.py);
      st3_in.ss   = st2_ff.ss;
      st3_in.dx   = st2_ff.dx;
      st3_in.dy   = st2_ff.dy;
      st3_in.s    = st2_ff.s;
      st3_in.msum = st2_ff.msum;
      st3_in.f    = st2_ff.f;
      st3_in.ma   = st2_ff.ma;
      st3_in.mb   = st2_ff.mb;
   end

   always_comb begin
      st4_in.flg.hit  = (st3_ff.d2 != '0) && (st3_ff.d2 < 50'(st3_ff.ss));
      st4_in.flg.nz   = st4_in.flg.hit && (st3_ff.ma != '0) && (st3_ff.mb != '0);
      st4_in.flg.appr = st3_ff.num[50] || (st3_ff.num == '0);
      st4_in.flg.negx = st3_ff.dx[24];
      st4_in.flg.negy = st3_ff.dy[24];
      st4_in.adx      = 17'(st3_ff.dx[24] ? -st3_ff.dx : st3_ff.dx);
      st4_in.ady      = 17'(st3_ff.dy[24] ? -st3_ff.dy : st3_ff.dy);
      st4_in.d2t      = st3_ff.d2[33:0];
      st4_in.numabs   = 42'(st3_ff.num[50] ? -st3_ff.num : st3_ff.num);
      st4_in.s        = st3_ff.s;
      st4_in.msum     = st3_ff.msum;
      st4_in.f        = st3_ff.f;
      st4_in.ma       = st3_ff.ma;
      st4_in.mb       = st3_ff.mb;
   end

   always_comb begin
      a_in          = 52'(st4_ff.f) * 52'(st4_ff.numabs);
      mt_in.mb_adx  = 41'(st4_ff.mb) * 41'(st4_ff.adx);
      mt_in.mb_ady  = 41'(st4_ff.mb) * 41'(st4_ff.ady);
      mt_in.ma_adx  = 41'(st4_ff.ma) * 41'(st4_ff.adx);
      mt_in.ma_ady  = 41'(st4_ff.ma) * 41'(st4_ff.ady);
      dv_in         = 59'(st4_ff.msum) * 59'(st4_ff.d2t);
      m5_in         = 28'(st4_ff.msum) + (28'(st4_ff.msum) << 2);
      s5_in         = st4_ff.s;
   end

   always_ff @(posedge clock) begin
      st1_ff  <= st1_in;
      st2_ff  <= st2_in;
      st3_ff  <= st3_in;
      st4_ff  <= st4_in;
      a_ff    <= a_in;
      mt_ff   <= mt_in;
      dv_ff   <= dv_in;
      m5_ff   <= m5_in;
      s5_ff   <= s5_in;
      ov4_ff  <= ov4_in;
      dpos_ff <= dpos_in;
   end

   // Velocity impulse: (1+e) * |closing| * m * |d| / (msum * d2), then scaled down by Q0.8.
   cpcr_mul #(.WA(52), .WB(41)) u_vmul_ax (.clock(clock), .a(a_ff), .b(mt_ff.mb_adx), .p(nv_ax));
   cpcr_mul #(.WA(52), .WB(41)) u_vmul_ay (.clock(clock), .a(a_ff), .b(mt_ff.mb_ady), .p(nv_ay));
   cpcr_mul #(.WA(52), .WB(41)) u_vmul_bx (.clock(clock), .a(a_ff), .b(mt_ff.ma_adx), .p(nv_bx));
   cpcr_mul #(.WA(52), .WB(41)) u_vmul_by (.clock(clock), .a(a_ff), .b(mt_ff.ma_ady), .p(nv_by));

   cpcr_delay #(.W(59), .DEPTH(3)) u_dv_dly (.clock(clock), .din(dv_ff), .dout(dv_d));

   cpcr_div #(.WN(93), .WD(67), .WQ(VEL_QW)) u_vdiv_ax (
      .clock(clock), .n(nv_ax), .d({dv_d, REST_SHIFT'(0)}), .q(vq.ax));
   cpcr_div #(.WN(93), .WD(67), .WQ(VEL_QW)) u_vdiv_ay (
      .clock(clock), .n(nv_ay), .d({dv_d, REST_SHIFT'(0)}), .q(vq.ay));
   cpcr_div #(.WN(93), .WD(67), .WQ(VEL_QW)) u_vdiv_bx (
      .clock(clock), .n(nv_bx), .d({dv_d, REST_SHIFT'(0)}), .q(vq.bx));
   cpcr_div #(.WN(93), .WD(67), .WQ(VEL_QW)) u_vdiv_by (
      .clock(clock), .n(nv_by), .d({dv_d, REST_SHIFT'(0)}), .q(vq.by));

   cpcr_delay #(.W($bits(vq_type)), .DEPTH(23)) u_vq_dly (.clock(clock), .din(vq), .dout(vq_d));

   // Position correction: 4/5 of the overlap, split by mass along the centre axis.
   cpcr_sqrt #(.WR(62)) u_sqrt (
      .clock(clock), .x({st4_ff.d2t, (2*DIST_EXTRA)'(0)}), .root(root));

   cpcr_delay #(.W(45), .DEPTH(30)) u_sm_dly (
      .clock(clock), .din({s5_ff, m5_ff}), .dout({s_a, m5_a}));
   cpcr_delay #(.W($bits(mterm_type)), .DEPTH(31)) u_mt_dly (
      .clock(clock), .din(mt_ff), .dout(mt_b));

   always_comb begin
      ov      = {s_a, DIST_EXTRA'(0)} - root;
      ov4_in  = {ov, 2'b00};
      dpos_in = 59'(m5_a) * 59'(root);
   end

   cpcr_mul #(.WA(33), .WB(41)) u_pmul_ax (.clock(clock), .a(ov4_ff), .b(mt_b.mb_adx), .p(np_ax));
   cpcr_mul #(.WA(33), .WB(41)) u_pmul_ay (.clock(clock), .a(ov4_ff), .b(mt_b.mb_ady), .p(np_ay));
   cpcr_mul #(.WA(33), .WB(41)) u_pmul_bx (.clock(clock), .a(ov4_ff), .b(mt_b.ma_adx), .p(np_bx));
   cpcr_mul #(.WA(33), .WB(41)) u_pmul_by (.clock(clock), .a(ov4_ff), .b(mt_b.ma_ady), .p(np_by));

   cpcr_delay #(.W(59), .DEPTH(3)) u_dpos_dly (.clock(clock), .din(dpos_ff), .dout(dpos_d));

   cpcr_div #(.WN(74), .WD(59), .WQ(POS_QW)) u_pdiv_ax (
      .clock(clock), .n(np_ax), .d(dpos_d), .q(pq_ax));
   cpcr_div #(.WN(74), .WD(59), .WQ(POS_QW)) u_pdiv_ay (
      .clock(clock), .n(np_ay), .d(dpos_d), .q(pq_ay));
   cpcr_div #(.WN(74), .WD(59), .WQ(POS_QW)) u_pdiv_bx (
      .clock(clock), .n(np_bx), .d(dpos_d), .q(pq_bx));
   cpcr_div #(.WN(74), .WD(59), .WQ(POS_QW)) u_pdiv_by (
      .clock(clock), .n(np_by), .d(dpos_d), .q(pq_by));

   // Side data aligned with the last quotient stage.
   assign kin_req = '{vax: req_vel_a_x, vay: req_vel_a_y, vbx: req_vel_b_x, vby: req_vel_b_y,
                      pax: req_pos_a_x, pay: req_pos_a_y, pbx: req_pos_b_x, pby: req_pos_b_y};

   cpcr_delay #(.W($bits(kin_type)), .DEPTH(LATENCY-1)) u_kin_dly (
      .clock(clock), .din(kin_req), .dout(kin_d));
   cpcr_delay #(.W($bits(flag_type)), .DEPTH(53)) u_flg_dly (
      .clock(clock), .din(st4_ff.flg), .dout(flg_d));

   always_comb begin
      res_in = kin_d;
      if (flg_d.nz) begin
         if (flg_d.appr) begin
            res_in.vax = adj_sat(kin_d.vax, 26'(vq_d.ax), !flg_d.negx);
            res_in.vay = adj_sat(kin_d.vay, 26'(vq_d.ay), !flg_d.negy);
            res_in.vbx = adj_sat(kin_d.vbx, 26'(vq_d.bx), flg_d.negx);
            res_in.vby = adj_sat(kin_d.vby, 26'(vq_d.by), flg_d.negy);
         end
         res_in.pax = adj_sat(kin_d.pax, 26'(pq_ax), !flg_d.negx);
         res_in.pay = adj_sat(kin_d.pay, 26'(pq_ay), !flg_d.negy);
         res_in.pbx = adj_sat(kin_d.pbx, 26'(pq_bx), flg_d.negx);
         res_in.pby = adj_sat(kin_d.pby, 26'(pq_by), flg_d.negy);
      end
      collided_in = flg_d.hit;
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      collided_ff <= collided_in;
   end

   assign rsp_valid       = valid_ff[LATENCY-1];
   assign rsp_collided    = collided_ff;
   assign rsp_new_vel_a_x = res_ff.vax;
   assign rsp_new_vel_a_y = res_ff.vay;
   assign rsp_new_vel_b_x = res_ff.vbx;
   assign rsp_new_vel_b_y = res_ff.vby;
   assign rsp_new_pos_a_x = res_ff.pax;
   assign rsp_new_pos_a_y = res_ff.pay;
   assign rsp_new_pos_b_x = res_ff.pbx;
   assign rsp_new_pos_b_y = res_ff.pby;

   a_pos_quot_bounded : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[LATENCY-2] && flg_d.nz) |->
         !(pq_ax[POS_QW] || pq_ay[POS_QW] || pq_bx[POS_QW] || pq_by[POS_QW]))
      else $error("Position correction quotient reached its clamp value.");

   a_miss_unchanged : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_collided) |->
         (rsp_new_pos_a_x == $past(kin_d.pax) && rsp_new_pos_b_y == $past(kin_d.pby) &&
          rsp_new_vel_a_x == $past(kin_d.vax) && rsp_new_vel_b_y == $past(kin_d.vby)))
      else $error("A pair without collision left the block modified.");

   a_separating_keeps_vel : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[LATENCY-2] && flg_d.nz && !flg_d.appr) |=>
         (rsp_new_vel_a_x == $past(kin_d.vax) && rsp_new_vel_a_y == $past(kin_d.vay) &&
          rsp_new_vel_b_x == $past(kin_d.vbx) && rsp_new_vel_b_y == $past(kin_d.vby)))
      else $error("A separating pair had its velocities changed.");

endmodule

>>> sv/cpcr_delay.sv
`timescale 1ns / 1ps
// Fixed-length shift line that keeps side data aligned with the arithmetic stages.
module cpcr_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] sh_ff [DEPTH];

   always_ff @(posedge clock) begin
      sh_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         sh_ff[i] <= sh_ff[i-1];
      end
   end

   assign dout = sh_ff[DEPTH-1];

endmodule

>>> sv/cpcr_mul.sv
`timescale 1ns / 1ps
// Pipelined unsigned multiplier that takes one 16-bit digit of the second operand per stage.
module cpcr_mul #(
   parameter int WA  = 52,
   parameter int WB  = 41,
   parameter int DIG = 16
) (
   input  logic             clock,
   input  logic [WA-1:0]    a,
   input  logic [WB-1:0]    b,
   output logic [WA+WB-1:0] p
);

   localparam int ND  = (WB + DIG - 1) / DIG;
   localparam int WBP = ND * DIG;
   localparam int WP  = WA + WB;

   logic [WA-1:0]  a_in   [ND];
   logic [WA-1:0]  a_ff   [ND];
   logic [WBP-1:0] b_in   [ND];
   logic [WBP-1:0] b_ff   [ND];
   logic [WP-1:0]  acc_in [ND];
   logic [WP-1:0]  acc_ff [ND];

   for (genvar g = 0; g < ND; g++) begin : g_stage
      logic [WA-1:0]  a_src;
      logic [WBP-1:0] b_src;
      logic [WP-1:0]  acc_src;
      if (g == 0) begin : g_first
         assign a_src   = a;
         assign b_src   = WBP'(b);
         assign acc_src = '0;
      end else begin : g_next
         assign a_src   = a_ff[g-1];
         assign b_src   = b_ff[g-1];
         assign acc_src = acc_ff[g-1];
      end
      assign a_in[g]   = a_src;
      assign b_in[g]   = b_src;
      assign acc_in[g] = acc_src + (WP'(a_src * b_src[g*DIG +: DIG]) << (g * DIG));
      always_ff @(posedge clock) begin
         a_ff[g]   <= a_in[g];
         b_ff[g]   <= b_in[g];
         acc_ff[g] <= acc_in[g];
      end
   end

   assign p = acc_ff[ND-1];

endmodule

>>> sv/cpcr_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, quotient clamped at 2**WQ.
module cpcr_div #(
   parameter int WN = 93,
   parameter int WD = 67,
   parameter int WQ = 25
) (
   input  logic          clock,
   input  logic [WN-1:0] n,
   input  logic [WD-1:0] d,
   output logic [WQ:0]   q
);

   localparam int WM = (WN > WD + WQ) ? WN : WD + WQ;

   logic [WN-1:0] rem_in [WQ+1];
   logic [WN-1:0] rem_ff [WQ+1];
   logic [WD-1:0] d_in   [WQ+1];
   logic [WD-1:0] d_ff   [WQ+1];
   logic [WQ-1:0] q_in   [WQ+1];
   logic [WQ-1:0] q_ff   [WQ+1];
   logic          cap_in [WQ+1];
   logic          cap_ff [WQ+1];

   assign rem_in[0] = n;
   assign d_in[0]   = d;
   assign q_in[0]   = '0;
   assign cap_in[0] = WM'(n) >= (WM'(d) << WQ);

   for (genvar k = 1; k <= WQ; k++) begin : g_step
      logic [WM-1:0] trial;
      logic          ge;
      assign trial     = WM'(d_ff[k-1]) << (WQ - k);
      assign ge        = WM'(rem_ff[k-1]) >= trial;
      assign rem_in[k] = ge ? WN'(WM'(rem_ff[k-1]) - trial) : rem_ff[k-1];
      assign d_in[k]   = d_ff[k-1];
      assign q_in[k]   = q_ff[k-1] | (ge ? (WQ'(1) << (WQ - k)) : WQ'(0));
      assign cap_in[k] = cap_ff[k-1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= WQ; i++) begin
         rem_ff[i] <= rem_in[i];
         d_ff[i]   <= d_in[i];
         q_ff[i]   <= q_in[i];
         cap_ff[i] <= cap_in[i];
      end
   end

   assign q = cap_ff[WQ] ? {1'b1, WQ'(0)} : {1'b0, q_ff[WQ]};

endmodule

>>> sv/cpcr_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, result rounded down.
module cpcr_sqrt #(
   parameter int WR = 62
) (
   input  logic            clock,
   input  logic [WR-1:0]   x,
   output logic [WR/2-1:0] root
);

   localparam int WO = WR / 2;

   logic [WR-1:0] x_in    [WO];
   logic [WR-1:0] x_ff    [WO];
   logic [WO:0]   rem_in  [WO];
   logic [WO:0]   rem_ff  [WO];
   logic [WO-1:0] root_in [WO];
   logic [WO-1:0] root_ff [WO];

   for (genvar k = 0; k < WO; k++) begin : g_step
      logic [WR-1:0] x_src;
      logic [WO:0]   rem_src;
      logic [WO-1:0] root_src;
      logic [WO+2:0] rem_t;
      logic [WO+2:0] trial;
      logic          ge;
      if (k == 0) begin : g_first
         assign x_src    = x;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign x_src    = x_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end
      assign rem_t      = {rem_src, x_src[WR-1 -: 2]};
      assign trial      = (WO+3)'({root_src, 2'b01});
      assign ge         = rem_t >= trial;
      assign rem_in[k]  = ge ? (WO+1)'(rem_t - trial) : (WO+1)'(rem_t);
      assign root_in[k] = {root_src[WO-2:0], ge};
      assign x_in[k]    = x_src << 2;
      always_ff @(posedge clock) begin
         x_ff[k]    <= x_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign root = root_ff[WO-1];

endmodule
